// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrB = 8'h62;
  localparam logic [7:0] ChrF = 8'h66;
  localparam logic [7:0] ChrN = 8'h6E;
  localparam logic [7:0] ChrR = 8'h72;
  localparam logic [7:0] ChrT = 8'h74;
  localparam logic [7:0] ChrU = 8'h75;

  localparam logic [15:0] Utf8TwoMin = 16'h0080;
  localparam logic [15:0] Utf8ThreeMin = 16'h0800;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont = 8'h80;

  typedef enum logic [1:0] {
    MODE_WAIT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX
  } mode_e;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_NO_OPEN  = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  // One queued word group: up to three bytes, cnt is number of words minus one.
  typedef struct packed {
    status_e    status;
    logic [1:0] cnt;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic entry_t utf8_enc(input logic [15:0] cp);
    entry_t e;
    e.status = ST_BYTE;
    e.b2 = 8'h00;
    e.b1 = 8'h00;
    if (cp < Utf8TwoMin) begin
      e.cnt = 2'd0;
      e.b0 = cp[7:0];
    end else if (cp < Utf8ThreeMin) begin
      e.cnt = 2'd1;
      e.b0 = Utf8Lead2 | {3'b000, cp[10:6]};
      e.b1 = Utf8Cont | {2'b00, cp[5:0]};
    end else begin
      e.cnt = 2'd2;
      e.b0 = Utf8Lead3 | {4'b0000, cp[15:12]};
      e.b1 = Utf8Cont | {2'b00, cp[11:6]};
      e.b2 = Utf8Cont | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== rtl/jsu_front.sv =====
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [7:0]      byte_value_i,
  input  logic            text_end_i,
  output logic            push_o,
  output jsu_pkg::entry_t push_entry_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] code_point_q, code_point_d;
  logic        accept;
  logic        emit;
  entry_t      ent;
  logic [15:0] cp_new;

  assign accept = in_valid_i && in_ready_i;
  assign cp_new = {code_point_q[11:0], hex_val(byte_value_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WAIT;
      hex_count_q  <= 2'd0;
      code_point_q <= 16'h0000;
    end else if (accept) begin
      mode_q       <= mode_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
    end
  end

  always_comb begin
    mode_d       = mode_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    emit         = 1'b0;
    ent          = '{status: ST_BYTE, cnt: 2'd0, b2: 8'h00, b1: 8'h00, b0: 8'h00};
    unique case (mode_q)
      MODE_WAIT: begin
        if (text_end_i || byte_value_i != ChrQuote) begin
          emit       = 1'b1;
          ent.status = ST_NO_OPEN;
        end else begin
          mode_d = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (text_end_i) begin
          emit       = 1'b1;
          ent.status = ST_TRUNC;
          mode_d     = MODE_WAIT;
        end else if (byte_value_i == ChrQuote) begin
          emit       = 1'b1;
          ent.status = ST_DONE;
          mode_d     = MODE_WAIT;
        end else if (byte_value_i == ChrBslash) begin
          mode_d = MODE_ESC;
        end else begin
          emit   = 1'b1;
          ent.b0 = byte_value_i;
        end
      end
      MODE_ESC: begin
        if (text_end_i) begin
          emit       = 1'b1;
          ent.status = ST_TRUNC;
          mode_d     = MODE_WAIT;
        end else begin
          emit   = 1'b1;
          mode_d = MODE_BODY;
          unique case (byte_value_i)
            ChrQuote, ChrBslash, ChrSlash: ent.b0 = byte_value_i;
            ChrB: ent.b0 = 8'h08;
            ChrF: ent.b0 = 8'h0C;
            ChrN: ent.b0 = 8'h0A;
            ChrR: ent.b0 = 8'h0D;
            ChrT: ent.b0 = 8'h09;
            ChrU: begin
              emit   = 1'b0;
              mode_d = MODE_HEX;
            end
            default: begin
              ent.status = ST_BAD_ESC;
              mode_d     = MODE_WAIT;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (text_end_i) begin
          emit       = 1'b1;
          ent.status = ST_TRUNC;
          mode_d     = MODE_WAIT;
        end else if (!is_hex(byte_value_i)) begin
          emit       = 1'b1;
          ent.status = ST_BAD_ESC;
          mode_d     = MODE_WAIT;
        end else if (hex_count_q != 2'd3) begin
          hex_count_d  = hex_count_q + 2'd1;
          code_point_d = cp_new;
        end else begin
          emit   = 1'b1;
          ent    = utf8_enc(cp_new);
          mode_d = MODE_BODY;
        end
      end
      default: mode_d = MODE_WAIT;
    endcase
    // hex state is only live while collecting digits
    if (mode_d != MODE_HEX) begin
      hex_count_d  = 2'd0;
      code_point_d = 16'h0000;
    end
  end

  assign push_o       = accept && emit;
  assign push_entry_o = ent;

  a_hex_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_HEX) |-> (hex_count_q == 2'd0 && code_point_q == 16'h0000))
    else $error("hex state not cleared outside hex mode");

endmodule

// ===== rtl/jsu_fifo.sv =====
module jsu_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jsu_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output jsu_pkg::entry_t pop_entry_o
);
  import jsu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntFull);
  assign empty_o     = (count_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count out of range");

endmodule

// ===== rtl/jsu_back.sv =====
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  jsu_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            last_o
);
  import jsu_pkg::*;

  logic       valid_q;
  entry_t     entry_q;
  logic [1:0] idx_q;
  logic       last_beat;
  logic       advance;

  assign last_beat = valid_q && (idx_q == entry_q.cnt);
  assign advance   = !valid_q || (out_ready_i && last_beat);
  assign pop_o     = advance && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (advance) begin
      valid_q <= !empty_i;
      idx_q   <= 2'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      entry_q <= entry_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = entry_q.b0;
      2'd1:    out_byte_o = entry_q.b1;
      default: out_byte_o = entry_q.b2;
    endcase
  end

  assign out_valid_o = valid_q;
  assign status_o    = entry_q.status;
  assign last_o      = last_beat;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= entry_q.cnt))
    else $error("word index past entry");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && entry_q.status != ST_BYTE) |-> (entry_q.cnt == 2'd0 && out_byte_o == 8'h00))
    else $error("status word not a lone zero word");

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Channel  Dir  tdata                          tuser  tlast
// s_axis   in   [7:0] byte_value               -      text_end
// m_axis   out  [7:0] out_byte, [10:8] status  -      last
//
// One input word per cycle unless the queue is full; a \u escape gives
// up to three output words, one per cycle while m_axis_tready is high,
// so output bandwidth limits UTF-8 bursts. Path: queue, back register.
// Reset clears mode, hex state, queue pointers and the output valid.
// s_axis_tready drops only when the QueueDepth-entry queue is full.
module json_string_unescape_utf8 #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic        m_axis_tlast
);
  import jsu_pkg::*;

  logic       push, full, pop, empty;
  entry_t     push_entry, pop_entry;
  logic [7:0] out_byte;
  logic [2:0] status;

  assign s_axis_tready = !full;

  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .byte_value_i (s_axis_tdata),
    .text_end_i   (s_axis_tlast),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .pop_entry_o  (pop_entry)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .status_o    (status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, status, out_byte};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import jsu_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumDirected = 24;
  localparam int RandomWords = 200;

  typedef struct packed {
    logic [7:0] ch;
    status_e    st;
    logic       lst;
  } out_word_t;

  typedef struct {
    bit         fin;
    logic [7:0] ch;
    bit         typed;
    logic [7:0] x_ch;
    status_e    x_st;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // decoder state mirror
  mode_e       dec_mode;
  logic [1:0]  hex_seen;
  logic [15:0] hex_acc;
  out_word_t   step_res[3];

  out_word_t   pending_words[$];
  dir_row_t    directed_rows[NumDirected];
  bit          jitter_on;
  int          cycle_cnt = 0;
  int          words_sent;
  int          words_checked;
  int          strings_opened;
  int          errors;

  json_string_unescape_utf8 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
               pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // returns the number of decoded words, placed in step_res
  function automatic int unescape_step(input bit fin, input logic [7:0] c);
    int n;
    int d;
    bit failed;
    status_e err;
    logic [15:0] cp;
    n = 0;
    failed = 1'b0;
    err = ST_BYTE;
    case (dec_mode)
      MODE_WAIT: begin
        if (fin || c != ChrQuote) begin
          failed = 1'b1;
          err = ST_NO_OPEN;
        end else begin
          dec_mode = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (fin) begin
          failed = 1'b1;
          err = ST_TRUNC;
        end else if (c == ChrQuote) begin
          dec_mode = MODE_WAIT;
          hex_seen = 2'd0;
          hex_acc = 16'h0000;
          step_res[0] = '{8'h00, ST_DONE, 1'b0};
          n = 1;
        end else if (c == ChrBslash) begin
          dec_mode = MODE_ESC;
        end else begin
          step_res[0] = '{c, ST_BYTE, 1'b0};
          n = 1;
        end
      end
      MODE_ESC: begin
        if (fin) begin
          failed = 1'b1;
          err = ST_TRUNC;
        end else begin
          dec_mode = MODE_BODY;
          n = 1;
          case (c)
            ChrQuote, ChrBslash, ChrSlash: step_res[0] = '{c, ST_BYTE, 1'b0};
            ChrB: step_res[0] = '{8'h08, ST_BYTE, 1'b0};
            ChrF: step_res[0] = '{8'h0C, ST_BYTE, 1'b0};
            ChrN: step_res[0] = '{8'h0A, ST_BYTE, 1'b0};
            ChrR: step_res[0] = '{8'h0D, ST_BYTE, 1'b0};
            ChrT: step_res[0] = '{8'h09, ST_BYTE, 1'b0};
            ChrU: begin
              dec_mode = MODE_HEX;
              hex_seen = 2'd0;
              hex_acc = 16'h0000;
              n = 0;
            end
            default: begin
              failed = 1'b1;
              err = ST_BAD_ESC;
              n = 0;
            end
          endcase
        end
      end
      default: begin
        if (c >= 8'h30 && c <= 8'h39) begin
          d = int'(c) - 48;
        end else if (c >= 8'h61 && c <= 8'h66) begin
          d = int'(c) - 87;
        end else if (c >= 8'h41 && c <= 8'h46) begin
          d = int'(c) - 55;
        end else begin
          d = -1;
        end
        if (fin) begin
          failed = 1'b1;
          err = ST_TRUNC;
        end else if (d < 0) begin
          failed = 1'b1;
          err = ST_BAD_ESC;
        end else begin
          cp = {hex_acc[11:0], d[3:0]};
          if (hex_seen != 2'd3) begin
            hex_seen = hex_seen + 2'd1;
            hex_acc = cp;
          end else begin
            if (cp < Utf8TwoMin) begin
              step_res[0] = '{cp[7:0], ST_BYTE, 1'b0};
              n = 1;
            end else if (cp < Utf8ThreeMin) begin
              step_res[0] = '{{3'b110, cp[10:6]}, ST_BYTE, 1'b0};
              step_res[1] = '{{2'b10, cp[5:0]}, ST_BYTE, 1'b0};
              n = 2;
            end else begin
              step_res[0] = '{{4'b1110, cp[15:12]}, ST_BYTE, 1'b0};
              step_res[1] = '{{2'b10, cp[11:6]}, ST_BYTE, 1'b0};
              step_res[2] = '{{2'b10, cp[5:0]}, ST_BYTE, 1'b0};
              n = 3;
            end
            dec_mode = MODE_BODY;
            hex_seen = 2'd0;
            hex_acc = 16'h0000;
          end
        end
      end
    endcase
    if (failed) begin
      dec_mode = MODE_WAIT;
      hex_seen = 2'd0;
      hex_acc = 16'h0000;
      step_res[0] = '{8'h00, err, 1'b0};
      n = 1;
    end
    if (n > 0) step_res[n-1].lst = 1'b1;
    return n;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input bit fin, input logic [7:0] c, input bit typed = 1'b0,
                           input logic [7:0] x_ch = 8'h00, input status_e x_st = ST_BYTE);
    int n;
    out_word_t w;
    while (jitter_on && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    n = unescape_step(fin, c);
    if (typed) begin
      w = '{x_ch, x_st, 1'b1};
      pending_words.insert(pending_words.size(), w);
    end else begin
      for (int i = 0; i < n; i++) pending_words.insert(pending_words.size(), step_res[i]);
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  // backslash, u and the leading ndig hex digits of cp, mixed case
  task automatic send_u_prefix(input logic [15:0] cp, input int ndig);
    logic [3:0] nib;
    send_word(1'b0, ChrBslash);
    send_word(1'b0, ChrU);
    for (int i = 0; i < ndig; i++) begin
      nib = cp[15-4*i -: 4];
      if (nib < 4'd10) send_word(1'b0, 8'h30 + {4'h0, nib});
      else if ($urandom_range(1)) send_word(1'b0, 8'h57 + {4'h0, nib});
      else send_word(1'b0, 8'h37 + {4'h0, nib});
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !(jitter_on && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: byte %02h status %0d last %0b", m_axis_tdata[7:0],
                   m_axis_tdata[10:8], m_axis_tlast);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        words_checked++;
        if (m_axis_tdata[7:0] !== exp_w.ch || m_axis_tdata[10:8] !== exp_w.st ||
            m_axis_tlast !== exp_w.lst) begin
          if (errors < 10)
            $display("word %0d: exp %02h/%0d/%0b got %02h/%0d/%0b (byte/status/last)",
                     words_checked, exp_w.ch, exp_w.st, exp_w.lst, m_axis_tdata[7:0],
                     m_axis_tdata[10:8], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int kind;
    logic [7:0] b;
    logic [15:0] cp;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    jitter_on = 1'b1;
    words_sent = 0;
    words_checked = 0;
    strings_opened = 0;
    errors = 0;
    dec_mode = MODE_WAIT;
    hex_seen = 2'd0;
    hex_acc = 16'h0000;
    directed_rows = '{
      '{1'b1, 8'h5A,     1'b1, 8'h00, ST_NO_OPEN},
      '{1'b0, 8'hFF,     1'b1, 8'h00, ST_NO_OPEN},
      '{1'b0, ChrQuote,  1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h00,     1'b1, 8'h00, ST_BYTE},
      '{1'b0, 8'hFF,     1'b1, 8'hFF, ST_BYTE},
      '{1'b0, ChrBslash, 1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrN,      1'b1, 8'h0A, ST_BYTE},
      '{1'b0, ChrBslash, 1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrU,      1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h46,     1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h66,     1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h46,     1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h66,     1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrBslash, 1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h71,     1'b1, 8'h00, ST_BAD_ESC},
      '{1'b0, ChrQuote,  1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrBslash, 1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrU,      1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h30,     1'b0, 8'h00, ST_BYTE},
      '{1'b0, 8'h67,     1'b1, 8'h00, ST_BAD_ESC},
      '{1'b0, ChrQuote,  1'b0, 8'h00, ST_BYTE},
      '{1'b1, 8'hA5,     1'b1, 8'h00, ST_TRUNC},
      '{1'b0, ChrQuote,  1'b0, 8'h00, ST_BYTE},
      '{1'b0, ChrQuote,  1'b1, 8'h00, ST_DONE}
    };
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].fin, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].x_ch, directed_rows[i].x_st);

    while (words_sent < NumDirected + RandomWords) begin
      jitter_on = !(words_sent >= 90 && words_sent < 160);
      kind = $urandom_range(99);
      if (kind < 12) begin
        // junk outside a string
        if ($urandom_range(1)) begin
          send_word(1'b1, 8'($urandom));
        end else begin
          b = 8'($urandom);
          if (b == ChrQuote) b = 8'h00;
          send_word(1'b0, b);
        end
      end else begin
        send_word(1'b0, ChrQuote);
        strings_opened++;
        repeat ($urandom_range(6)) begin
          kind = $urandom_range(9);
          if (kind < 5) begin
            do b = 8'($urandom); while (b inside {ChrQuote, ChrBslash});
            send_word(1'b0, b);
          end else if (kind < 7) begin
            case ($urandom_range(7))
              0: b = ChrQuote;
              1: b = ChrBslash;
              2: b = ChrSlash;
              3: b = ChrB;
              4: b = ChrF;
              5: b = ChrN;
              6: b = ChrR;
              default: b = ChrT;
            endcase
            send_word(1'b0, ChrBslash);
            send_word(1'b0, b);
          end else begin
            case ($urandom_range(3))
              0: cp = 16'($urandom_range(16'h007F));
              1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
              2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
              default: begin
                case ($urandom_range(5))
                  0: cp = 16'h0000;
                  1: cp = 16'h007F;
                  2: cp = 16'h0080;
                  3: cp = 16'h07FF;
                  4: cp = 16'h0800;
                  default: cp = 16'hFFFF;
                endcase
              end
            endcase
            send_u_prefix(cp, 4);
          end
        end
        if ($urandom_range(9) < 8) begin
          send_word(1'b0, ChrQuote);
        end else begin
          cp = 16'($urandom);
          case ($urandom_range(4))
            0: send_word(1'b1, 8'($urandom));
            1: begin
              send_word(1'b0, ChrBslash);
              send_word(1'b1, 8'($urandom));
            end
            2: begin
              do b = 8'($urandom);
              while (b inside {ChrQuote, ChrBslash, ChrSlash, ChrB, ChrF, ChrN, ChrR, ChrT,
                               ChrU});
              send_word(1'b0, ChrBslash);
              send_word(1'b0, b);
            end
            3: begin
              do b = 8'($urandom);
              while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
              send_u_prefix(cp, $urandom_range(3));
              send_word(1'b0, b);
            end
            default: begin
              send_u_prefix(cp, $urandom_range(3));
              send_word(1'b1, 8'($urandom));
            end
          endcase
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    jitter_on = 1'b1;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d input words, %0d strings opened (escapes, UTF-8 and error paths)",
             words_sent, strings_opened);
    $display("checked %0d output words, %0d errors", words_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
